// ===== design/idp_pkg.sv =====
// Shared types and constants for the ISO 8601 duration parser.
package idp_pkg;

	localparam int unsigned FIELD_W = 31;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned PROD_W  = FIELD_W + 4;

	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_Y    = 8'h59;
	localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
	localparam logic [CHAR_W-1:0] CH_H    = 8'h48;
	localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
	localparam logic [CHAR_W-1:0] CH_T    = 8'h54;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_YEAR,
		TK_MONTH_MIN,
		TK_DAY,
		TK_HOUR,
		TK_SEC,
		TK_TIME,
		TK_BAD
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [DIGIT_W-1:0] digit;
		logic               first;
		logic               last;
	} tok_t;

endpackage

// ===== design/idp_front.sv =====
// Input side: accepts characters and classifies them into tokens.
module idp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [idp_pkg::CHAR_W-1:0]   char_code,
	input  logic                         is_final,
	input  logic                         q_full,
	output logic                         push,
	output idp_pkg::tok_t                push_tok
);
	import idp_pkg::*;

	logic      first_q;
	tok_kind_t kind;

	always_comb begin
		case (char_code)
			CH_Y:    kind = TK_YEAR;
			CH_M:    kind = TK_MONTH_MIN;
			CH_D:    kind = TK_DAY;
			CH_H:    kind = TK_HOUR;
			CH_S:    kind = TK_SEC;
			CH_T:    kind = TK_TIME;
			default: kind = (char_code >= CH_ZERO && char_code <= CH_NINE) ? TK_DIGIT : TK_BAD;
		endcase
	end

	logic [CHAR_W-1:0] digit_full;
	assign digit_full = char_code - CH_ZERO;

	assign in_stall       = q_full;
	assign push           = in_valid && !q_full;
	assign push_tok.kind  = kind;
	assign push_tok.digit = digit_full[DIGIT_W-1:0];
	assign push_tok.first = first_q;
	assign push_tok.last  = is_final;

	// next transfer starts a new string after a final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (push) begin
			first_q <= is_final;
		end
	end

endmodule

// ===== design/idp_queue.sv =====
// Two-entry token queue between the front and back ends.
module idp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  idp_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output idp_pkg::tok_t pop_tok
);
	import idp_pkg::*;

	tok_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign pop_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/idp_back.sv =====
// Back end: number accumulation, field storage and the result register.
module idp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  idp_pkg::tok_t                tok,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [idp_pkg::FIELD_W-1:0]  years_out,
	output logic [idp_pkg::FIELD_W-1:0]  months_out,
	output logic [idp_pkg::FIELD_W-1:0]  days_out,
	output logic [idp_pkg::FIELD_W-1:0]  hours_out,
	output logic [idp_pkg::FIELD_W-1:0]  minutes_out,
	output logic [idp_pkg::FIELD_W-1:0]  seconds_out,
	output logic                         parse_ok
);
	import idp_pkg::*;

	logic               date_q, failed_q, out_valid_q;
	logic [FIELD_W-1:0] acc_q, year_q, month_q, day_q, hour_q, minute_q, second_q;

	logic               date_d, failed_d;
	logic [FIELD_W-1:0] acc_d, year_d, month_d, day_d, hour_d, minute_d, second_d;
	logic [PROD_W-1:0]  prod;

	assign prod = ({{(PROD_W-FIELD_W){1'b0}}, acc_q} << 3)
		+ ({{(PROD_W-FIELD_W){1'b0}}, acc_q} << 1)
		+ {{(PROD_W-DIGIT_W){1'b0}}, tok.digit};

	assign pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		date_d   = date_q;
		failed_d = failed_q;
		acc_d    = acc_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		if (tok.first) begin
			date_d   = 1'b1;
			failed_d = 1'b0;
			acc_d    = '0;
			year_d   = '0;
			month_d  = '0;
			day_d    = '0;
			hour_d   = '0;
			minute_d = '0;
			second_d = '0;
		end else if (!failed_q) begin
			if (tok.kind != TK_DIGIT) begin
				acc_d = '0;
			end
			case (tok.kind)
				TK_DIGIT: begin
					if (prod[PROD_W-1:FIELD_W] != '0) begin
						failed_d = 1'b1;
					end else begin
						acc_d = prod[FIELD_W-1:0];
					end
				end
				TK_YEAR: year_d = acc_q;
				TK_MONTH_MIN: begin
					if (date_q) begin
						month_d = acc_q;
					end else begin
						minute_d = acc_q;
					end
				end
				TK_DAY:  day_d = acc_q;
				TK_HOUR: hour_d = acc_q;
				TK_SEC:  second_d = acc_q;
				TK_TIME: date_d = 1'b0;
				default: failed_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q      <= 1'b1;
			failed_q    <= 1'b0;
			acc_q       <= '0;
			year_q      <= '0;
			month_q     <= '0;
			day_q       <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				date_q   <= date_d;
				failed_q <= failed_d;
				acc_q    <= acc_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
			end
			if (pop && tok.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only when a final token leaves the queue
	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			years_out   <= year_d;
			months_out  <= month_d;
			days_out    <= day_d;
			hours_out   <= hour_d;
			minutes_out <= minute_d;
			seconds_out <= second_d;
			parse_ok    <= !failed_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/iso_duration_parser_core.sv =====
// Top level of the ISO 8601 duration parser.
// Throughput: one character per cycle while the queue is not full; the back
// end takes one token a cycle from a two-entry queue and stalls only while
// the result register is held. A final token's result is registered there.
// Reset: asynchronous, active low; clears the queue, the parse state and the
// result valid; the first character after reset starts a new string.
module iso_duration_parser_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [idp_pkg::CHAR_W-1:0]   char_code,
	input  logic                         is_final,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [idp_pkg::FIELD_W-1:0]  years_out,
	output logic [idp_pkg::FIELD_W-1:0]  months_out,
	output logic [idp_pkg::FIELD_W-1:0]  days_out,
	output logic [idp_pkg::FIELD_W-1:0]  hours_out,
	output logic [idp_pkg::FIELD_W-1:0]  minutes_out,
	output logic [idp_pkg::FIELD_W-1:0]  seconds_out,
	output logic                         parse_ok
);
	import idp_pkg::*;

	logic push, q_full, pop, q_valid;
	tok_t push_tok, pop_tok;

	idp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_code(char_code),
		.is_final (is_final),
		.q_full   (q_full),
		.push     (push),
		.push_tok (push_tok)
	);

	idp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_tok(push_tok),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.pop_tok (pop_tok)
	);

	idp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.tok        (pop_tok),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.years_out  (years_out),
		.months_out (months_out),
		.days_out   (days_out),
		.hours_out  (hours_out),
		.minutes_out(minutes_out),
		.seconds_out(seconds_out),
		.parse_ok   (parse_ok)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for iso_duration_parser_core: random duration strings, scoreboard check.

typedef enum int {F_YEARS, F_MONTHS, F_DAYS, F_HOURS, F_MINUTES, F_SECONDS} field_idx_t;

typedef struct packed {
	logic [5:0][idp_pkg::FIELD_W-1:0] fld;
	logic                             ok;
} duration_t;

class duration_scoreboard;
	bit                               fresh = 1'b1;
	bit                               in_date = 1'b1;
	bit                               bad = 1'b0;
	bit [idp_pkg::FIELD_W-1:0]        acc = '0;
	bit [5:0][idp_pkg::FIELD_W-1:0]   fld = '0;
	duration_t                        awaited[$];
	int                               errors = 0;

	function void take(logic [idp_pkg::CHAR_W-1:0] c);
		bit [idp_pkg::PROD_W-1:0]  nxt;
		bit [idp_pkg::FIELD_W-1:0] n;
		n = acc;
		if (c >= idp_pkg::CH_ZERO && c <= idp_pkg::CH_NINE) begin
			nxt = acc;
			nxt = nxt * 10 + (c - idp_pkg::CH_ZERO);
			if (nxt > 35'h7FFF_FFFF)
				bad = 1'b1;
			else
				acc = nxt[idp_pkg::FIELD_W-1:0];
			return;
		end
		acc = '0;
		case (c)
			idp_pkg::CH_Y: fld[F_YEARS] = n;
			idp_pkg::CH_M: begin
				if (in_date)
					fld[F_MONTHS] = n;
				else
					fld[F_MINUTES] = n;
			end
			idp_pkg::CH_D: fld[F_DAYS] = n;
			idp_pkg::CH_H: fld[F_HOURS] = n;
			idp_pkg::CH_S: fld[F_SECONDS] = n;
			idp_pkg::CH_T: in_date = 1'b0;
			default: bad = 1'b1;
		endcase
	endfunction

	function void note_char(logic [idp_pkg::CHAR_W-1:0] c, logic fin);
		duration_t want;
		if (fresh) begin
			in_date = 1'b1;
			acc = '0;
			bad = 1'b0;
			fld = '0;
			fresh = 1'b0;
		end else if (!bad) begin
			take(c);
		end
		if (fin) begin
			want.fld = fld;
			want.ok = !bad;
			awaited.push_back(want);
			fresh = 1'b1;
		end
	endfunction

	function void check_result(duration_t got);
		duration_t want;
		string     names[6];
		names = '{"years", "months", "days", "hours", "minutes", "seconds"};
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			return;
		end
		want = awaited.pop_front();
		for (int i = 0; i < 6; i++)
			if (got.fld[i] !== want.fld[i]) begin
				errors++;
				$display("%0t: %s expected %0d, actual %0d", $time, names[i],
					want.fld[i], got.fld[i]);
			end
		if (got.ok !== want.ok) begin
			errors++;
			$display("%0t: parse_ok expected %0b, actual %0b", $time, want.ok, got.ok);
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module tb;
	import idp_pkg::*;

	localparam logic [CHAR_W-1:0] CH_P = 8'h50;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CHAR_W-1:0]   char_code;
	logic                is_final;
	logic                out_valid;
	logic                out_stall;
	logic [FIELD_W-1:0]  years_out;
	logic [FIELD_W-1:0]  months_out;
	logic [FIELD_W-1:0]  days_out;
	logic [FIELD_W-1:0]  hours_out;
	logic [FIELD_W-1:0]  minutes_out;
	logic [FIELD_W-1:0]  seconds_out;
	logic                parse_ok;

	duration_scoreboard  sb = new;
	logic [CHAR_W-1:0]   text_q[$];
	int                  sent = 0;
	bit                  steady = 1'b0;

	iso_duration_parser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.is_final    (is_final),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.years_out   (years_out),
		.months_out  (months_out),
		.days_out    (days_out),
		.hours_out   (hours_out),
		.minutes_out (minutes_out),
		.seconds_out (seconds_out),
		.parse_ok    (parse_ok)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_mark();
		case ($urandom_range(0, 5))
			0: return CH_Y;
			1: return CH_M;
			2: return CH_D;
			3: return CH_H;
			4: return CH_S;
			default: return CH_T;
		endcase
	endfunction

	function automatic void add_number();
		longint unsigned v;
		string           digs;
		int              r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return;
		else if (r < 55)
			v = $urandom_range(0, 99);
		else if (r < 75)
			v = $urandom_range(0, 999999);
		else if (r < 85)
			v = $urandom;
		else if (r < 93)
			v = 64'd2147483647 - $urandom_range(0, 20);
		else if (r < 98)
			v = 64'd2147483648 + $urandom_range(0, 30);
		else
			v = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			text_q.push_back(CH_ZERO);
		digs = $sformatf("%0d", v);
		for (int i = 0; i < digs.len(); i++)
			text_q.push_back(digs[i]);
	endfunction

	function automatic void add_field(logic [CHAR_W-1:0] mark);
		add_number();
		text_q.push_back(mark);
	endfunction

	function automatic void build_string();
		int n;
		text_q.delete();
		text_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_P);
		if ($urandom_range(0, 99) < 75) begin
			if ($urandom_range(0, 1)) add_field(CH_Y);
			if ($urandom_range(0, 1)) add_field(CH_M);
			if ($urandom_range(0, 1)) add_field(CH_D);
			if ($urandom_range(0, 9) < 6) begin
				text_q.push_back(CH_T);
				if ($urandom_range(0, 1)) add_field(CH_H);
				if ($urandom_range(0, 1)) add_field(CH_M);
				if ($urandom_range(0, 1)) add_field(CH_S);
			end
			if ($urandom_range(0, 7) == 0)
				add_field(pick_mark());
			if ($urandom_range(0, 9) == 0)
				add_number();
			if ($urandom_range(0, 11) == 0 && text_q.size() > 1)
				text_q.insert($urandom_range(1, text_q.size() - 1),
					8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 12);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
					4, 5, 6:    text_q.push_back(pick_mark());
					default:    text_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endfunction

	task automatic idle(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		in_valid  <= 1'b1;
		char_code <= c;
		is_final  <= fin;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_string();
		for (int i = 0; i < text_q.size(); i++) begin
			if (!steady)
				idle(gap_len());
			send_char(text_q[i], i == text_q.size() - 1);
		end
	endtask

	task automatic send_text(input string t);
		text_q.delete();
		for (int i = 0; i < t.len(); i++)
			text_q.push_back(t[i]);
		send_string();
	endtask

	// one edge first so the last transfer is already noted
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// output side back-pressure
	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			n = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 8);
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		duration_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_char(char_code, is_final);
			if (out_valid && !out_stall) begin
				got.fld = {seconds_out, minutes_out, hours_out, days_out, months_out,
					years_out};
				got.ok = parse_ok;
				sb.check_result(got);
			end
		end
	end

	initial begin
		bit drained_mid;
		drained_mid = 1'b0;
		in_valid  <= 1'b0;
		char_code <= '0;
		is_final  <= 1'b0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		steady = 1'b1;
		send_text("P");
		send_text("P1Y2M3DT4H5M6S");
		text_q = '{8'hFF, CH_M, "7"};
		send_string();
		text_q = '{8'h00, "4", 8'h00};
		send_string();
		steady = 1'b0;
		send_text("P5D6y");
		drain();

		while (sent < 1330) begin
			steady = ($urandom_range(0, 7) == 0);
			build_string();
			send_string();
			if (!drained_mid && sent > 700) begin
				drain();
				drained_mid = 1'b1;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
